// ===== sv/tmdu_pkg.sv =====
// Package: op codes and state type for the tape machine data unit.
`timescale 1ns / 1ps

package tmdu_pkg;

  // Primitive op codes carried by an input item
  typedef enum logic [2:0] {
    OP_RIGHT = 3'd0,
    OP_LEFT  = 3'd1,
    OP_INC   = 3'd2,
    OP_DEC   = 3'd3,
    OP_OUT   = 3'd4,
    OP_IN    = 3'd5,
    OP_TEST  = 3'd6
  } op_t;

  // Control states of the data unit
  typedef enum logic {
    ST_RUN,
    ST_LOAD
  } state_t;

endpackage

// ===== sv/tmdu_if.sv =====
// Interfaces: op channel into the data unit and result channel out of it.
`timescale 1ns / 1ps

interface tmdu_in_if;
  logic           valid;
  logic           ready;
  tmdu_pkg::op_t  op;
  logic [7:0]     in_byte;
  logic           in_eof;

  modport source (output valid, output op, output in_byte, output in_eof, input ready);
  modport sink   (input valid, input op, input in_byte, input in_eof, output ready);
endinterface

interface tmdu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       cell_zero;
  logic       fault;

  modport source (output valid, output out_byte, output out_valid, output cell_zero,
                  output fault, input ready);
  modport sink   (input valid, input out_byte, input out_valid, input cell_zero,
                  input fault, output ready);
endinterface

// ===== sv/tape_machine_data_unit.sv =====
// Tape machine data unit: byte-cell tape in one RAM with a cached current cell.
//
// Each accepted item carries one op and yields exactly one result item. Cell ops
// (increment, decrement, input, output, test) and any op after a fault finish
// in the run state: the current cell lives in a register and is written through
// to the tape RAM. A pointer move goes on to the load state, which takes the new
// cell from the registered read port of the tape RAM. A result register sits on
// the output; an item is taken only while that register is empty or its result
// leaves in the same cycle. The tape needs no clearing
// pass after reset: a fill count marks how far the pointer has ever walked, and
// cells at or beyond it read as zero. Moving right from the last cell or left from
// cell 0 sets a sticky fault; from then on every op only reports.
`timescale 1ns / 1ps

module tape_machine_data_unit #(
  parameter int TAPE_CELLS = 32768
) (
  input  logic               clk,
  input  logic               rst_n,
  tmdu_in_if.sink            in_if,
  tmdu_out_if.source         out_if
);

  localparam int PW = (TAPE_CELLS > 2) ? $clog2(TAPE_CELLS) : 1;
  localparam int FW = $clog2(TAPE_CELLS + 1);
  localparam logic [PW-1:0] LAST_CELL = PW'(TAPE_CELLS - 1);

  // Tape RAM: one write port, one registered read port
  logic [7:0]    tape_mem [TAPE_CELLS];
  logic [7:0]    rd_data_r;
  logic          mem_we;
  logic [PW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [PW-1:0] mem_raddr;

  tmdu_pkg::state_t state_r, state_nxt;
  logic [PW-1:0]    ptr_r, ptr_nxt;
  logic [FW-1:0]    fill_r, fill_nxt;
  logic [7:0]       cur_r, cur_nxt;
  logic             halt_r, halt_nxt;

  logic             res_vld_r, res_vld_nxt;
  logic [7:0]       res_byte_r, res_byte_nxt;
  logic             res_ov_r, res_ov_nxt;
  logic             res_cz_r, res_cz_nxt;
  logic             res_fault_r, res_fault_nxt;

  logic             slot_free;
  logic             accept;
  logic             to_load;
  logic [7:0]       load_val;

  assign slot_free   = !res_vld_r || out_if.ready;
  assign in_if.ready = (state_r == tmdu_pkg::ST_RUN) && slot_free;
  assign accept      = in_if.valid && in_if.ready;

  // Cells beyond the fill count were never written since reset
  assign load_val = (fill_r > FW'(ptr_r)) ? rd_data_r : 8'd0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tape_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= tape_mem[mem_raddr];
    end
  end

  // Next state, tape access and result
  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    fill_nxt      = fill_r;
    cur_nxt       = cur_r;
    halt_nxt      = halt_r;
    res_vld_nxt   = res_vld_r && !out_if.ready;
    res_byte_nxt  = res_byte_r;
    res_ov_nxt    = res_ov_r;
    res_cz_nxt    = res_cz_r;
    res_fault_nxt = res_fault_r;
    mem_we        = 1'b0;
    mem_waddr     = ptr_r;
    mem_wdata     = cur_r;
    mem_re        = 1'b0;
    mem_raddr     = ptr_r;
    to_load       = 1'b0;

    unique case (state_r)
      tmdu_pkg::ST_RUN: begin
        if (accept) begin
          res_byte_nxt = 8'd0;
          res_ov_nxt   = 1'b0;
          if (!halt_r) begin
            case (in_if.op)
              tmdu_pkg::OP_RIGHT: begin
                if (ptr_r == LAST_CELL) begin
                  halt_nxt = 1'b1;
                end else begin
                  ptr_nxt   = ptr_r + PW'(1);
                  mem_re    = 1'b1;
                  mem_raddr = ptr_r + PW'(1);
                  to_load   = 1'b1;
                end
              end
              tmdu_pkg::OP_LEFT: begin
                if (ptr_r == '0) begin
                  halt_nxt = 1'b1;
                end else begin
                  ptr_nxt   = ptr_r - PW'(1);
                  mem_re    = 1'b1;
                  mem_raddr = ptr_r - PW'(1);
                  to_load   = 1'b1;
                end
              end
              tmdu_pkg::OP_INC: cur_nxt = cur_r + 8'd1;
              tmdu_pkg::OP_DEC: cur_nxt = cur_r - 8'd1;
              tmdu_pkg::OP_OUT: begin
                res_byte_nxt = cur_r;
                res_ov_nxt   = 1'b1;
              end
              tmdu_pkg::OP_IN: begin
                if (!in_if.in_eof) begin
                  cur_nxt = in_if.in_byte;
                end
              end
              default: ;
            endcase
            // Write the cell through and extend the fill count on a fresh cell
            mem_we    = 1'b1;
            mem_wdata = cur_nxt;
            if (fill_r == FW'(ptr_r)) begin
              fill_nxt = fill_r + FW'(1);
            end
          end
          if (to_load) begin
            state_nxt = tmdu_pkg::ST_LOAD;
          end else begin
            res_vld_nxt   = 1'b1;
            res_cz_nxt    = (cur_nxt == 8'd0);
            res_fault_nxt = halt_nxt;
          end
        end
      end
      tmdu_pkg::ST_LOAD: begin
        // Take the new cell once the result register is free
        if (slot_free) begin
          cur_nxt       = load_val;
          res_vld_nxt   = 1'b1;
          res_byte_nxt  = 8'd0;
          res_ov_nxt    = 1'b0;
          res_cz_nxt    = (load_val == 8'd0);
          res_fault_nxt = 1'b0;
          state_nxt     = tmdu_pkg::ST_RUN;
        end
      end
      default: state_nxt = tmdu_pkg::ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tmdu_pkg::ST_RUN;
      ptr_r     <= '0;
      fill_r    <= '0;
      cur_r     <= 8'd0;
      halt_r    <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ptr_r     <= ptr_nxt;
      fill_r    <= fill_nxt;
      cur_r     <= cur_nxt;
      halt_r    <= halt_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    res_byte_r  <= res_byte_nxt;
    res_ov_r    <= res_ov_nxt;
    res_cz_r    <= res_cz_nxt;
    res_fault_r <= res_fault_nxt;
  end

  assign out_if.valid     = res_vld_r;
  assign out_if.out_byte  = res_byte_r;
  assign out_if.out_valid = res_ov_r;
  assign out_if.cell_zero = res_cz_r;
  assign out_if.fault     = res_fault_r;

endmodule

// ===== tb/sv/tape_machine_data_unit_tb.sv =====
// Testbench: directed table plus random op streams for the tape machine data unit.
`timescale 1ns / 1ps

module tape_machine_data_unit_tb;

  localparam int TAPE_CELLS   = 32768;
  localparam int LAST_CELL    = TAPE_CELLS - 1;
  localparam int RANDOM_ITEMS = 1000;
  localparam int CYCLE_LIMIT  = 800000;
  localparam int TAIL_CYCLES  = 20;
  localparam int IDLE_PCT     = 11;
  localparam int CALM_FIRST   = 500;
  localparam int CALM_LAST    = 750;
  // op code 7 is outside the enum and must behave like a cell test
  localparam logic [2:0] OP_SPARE = 3'd7;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       cell_zero;
    logic       fault;
  } result_t;

  typedef struct packed {
    logic [2:0] code;
    logic [7:0] data;
    logic       eof;
    logic       typed;
    result_t    want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  tmdu_in_if  op_ch ();
  tmdu_out_if res_ch ();

  tape_machine_data_unit #(
    .TAPE_CELLS(TAPE_CELLS)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (op_ch),
    .out_if (res_ch)
  );

  // Shadow copy of the tape and its pointer
  logic [7:0]  tape_mem [TAPE_CELLS];
  int unsigned cell_ptr;
  int unsigned ptr_peak;
  bit          tape_halted;

  result_t     pending_results [$];
  stim_row_t   directed_ops [24];

  bit          calm;
  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned outs_checked;
  string       fault_side;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Apply one op to the shadow tape and return the result it should produce
  function automatic result_t tape_step(logic [2:0] code, logic [7:0] data, logic eof);
    result_t r;
    r = '0;
    if (!tape_halted) begin
      case (code)
        tmdu_pkg::OP_RIGHT: begin
          if (cell_ptr < LAST_CELL) cell_ptr = cell_ptr + 1;
          else tape_halted = 1'b1;
        end
        tmdu_pkg::OP_LEFT: begin
          if (cell_ptr > 0) cell_ptr = cell_ptr - 1;
          else tape_halted = 1'b1;
        end
        tmdu_pkg::OP_INC: tape_mem[cell_ptr] = tape_mem[cell_ptr] + 8'd1;
        tmdu_pkg::OP_DEC: tape_mem[cell_ptr] = tape_mem[cell_ptr] - 8'd1;
        tmdu_pkg::OP_OUT: begin
          r.out_byte  = tape_mem[cell_ptr];
          r.out_valid = 1'b1;
        end
        tmdu_pkg::OP_IN: begin
          if (!eof) tape_mem[cell_ptr] = data;
        end
        default: ;
      endcase
    end
    if (cell_ptr > ptr_peak) ptr_peak = cell_ptr;
    r.cell_zero = (tape_mem[cell_ptr] == 8'd0);
    r.fault     = tape_halted;
    return r;
  endfunction

  // Offer one item, hold it until taken, then queue what it should produce
  task automatic send_op(logic [2:0] code, logic [7:0] data, logic eof,
                         bit typed = 1'b0, result_t want = '0);
    result_t r;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      op_ch.valid <= 1'b0;
      @(posedge clk);
    end
    op_ch.valid   <= 1'b1;
    op_ch.op      <= tmdu_pkg::op_t'(code);
    op_ch.in_byte <= data;
    op_ch.in_eof  <= eof;
    do @(posedge clk); while (!op_ch.ready);
    r = tape_step(code, data, eof);
    pending_results.insert(pending_results.size(), typed ? want : r);
    items_sent++;
  endtask

  // Hold the sender off until every queued result has come back
  task automatic drain_results();
    op_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic send_random_op(logic [2:0] code);
    logic [7:0] data;
    data = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
    send_op(code, data, ($urandom_range(0, 3) == 0));
  endtask

  // Pick a cell op or a move that keeps the pointer on the tape
  function automatic logic [2:0] pick_op();
    int unsigned w;
    logic [2:0]  code;
    w = $urandom_range(0, 99);
    if (w < 18)      code = tmdu_pkg::OP_RIGHT;
    else if (w < 36) code = tmdu_pkg::OP_LEFT;
    else if (w < 51) code = tmdu_pkg::OP_INC;
    else if (w < 66) code = tmdu_pkg::OP_DEC;
    else if (w < 78) code = tmdu_pkg::OP_OUT;
    else if (w < 92) code = tmdu_pkg::OP_IN;
    else if (w < 97) code = tmdu_pkg::OP_TEST;
    else             code = OP_SPARE;
    if (code == tmdu_pkg::OP_LEFT && cell_ptr == 0) code = tmdu_pkg::OP_RIGHT;
    if (code == tmdu_pkg::OP_RIGHT && cell_ptr == LAST_CELL) code = tmdu_pkg::OP_LEFT;
    return code;
  endfunction

  // Result side: random stalls, checked against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.out_byte, res_ch.out_valid, res_ch.cell_zero, res_ch.fault};
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: byte=%02h valid=%b zero=%b fault=%b",
                   got.out_byte, got.out_valid, got.cell_zero, got.fault);
      end else begin
        want = pending_results.pop_front();
        outs_checked++;
        if (got.out_byte !== want.out_byte || got.out_valid !== want.out_valid ||
            got.cell_zero !== want.cell_zero || got.fault !== want.fault) begin
          fail_count++;
          if (fail_count <= 10)
            $display({"mismatch at result %0d: exp byte=%02h valid=%b zero=%b fault=%b,",
                      " got byte=%02h valid=%b zero=%b fault=%b"},
                     outs_checked, want.out_byte, want.out_valid, want.cell_zero,
                     want.fault, got.out_byte, got.out_valid, got.cell_zero, got.fault);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    int unsigned burst_len;
    bit          go_right;
    logic [2:0]  code;

    rst_n          = 1'b0;
    op_ch.valid    = 1'b0;
    op_ch.op       = tmdu_pkg::OP_TEST;
    op_ch.in_byte  = 8'd0;
    op_ch.in_eof   = 1'b0;
    calm           = 1'b0;
    cycle_count    = 0;
    fail_count     = 0;
    items_sent     = 0;
    outs_checked   = 0;
    cell_ptr       = 0;
    ptr_peak       = 0;
    tape_halted    = 1'b0;
    foreach (tape_mem[i]) tape_mem[i] = 8'd0;

    // Directed ops: wraps, input with and without a byte, fresh cells, spare code
    directed_ops = '{
      '{tmdu_pkg::OP_TEST,  8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},
      '{tmdu_pkg::OP_OUT,   8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},
      '{tmdu_pkg::OP_DEC,   8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}},
      '{tmdu_pkg::OP_OUT,   8'h00, 1'b0, 1'b1, '{8'hff, 1'b1, 1'b0, 1'b0}},
      '{tmdu_pkg::OP_INC,   8'hff, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},
      '{tmdu_pkg::OP_IN,    8'ha5, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}},
      '{tmdu_pkg::OP_OUT,   8'h00, 1'b0, 1'b1, '{8'ha5, 1'b1, 1'b0, 1'b0}},
      '{tmdu_pkg::OP_IN,    8'h3c, 1'b1, 1'b0, '0},
      '{tmdu_pkg::OP_OUT,   8'h00, 1'b0, 1'b0, '0},
      '{tmdu_pkg::OP_IN,    8'hff, 1'b0, 1'b0, '0},
      '{tmdu_pkg::OP_INC,   8'h00, 1'b0, 1'b0, '0},
      '{tmdu_pkg::OP_IN,    8'h80, 1'b0, 1'b0, '0},
      '{tmdu_pkg::OP_RIGHT, 8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},
      '{tmdu_pkg::OP_OUT,   8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},
      '{tmdu_pkg::OP_IN,    8'h01, 1'b0, 1'b0, '0},
      '{tmdu_pkg::OP_RIGHT, 8'h55, 1'b1, 1'b0, '0},
      '{tmdu_pkg::OP_RIGHT, 8'haa, 1'b0, 1'b0, '0},
      '{tmdu_pkg::OP_LEFT,  8'h00, 1'b0, 1'b0, '0},
      '{tmdu_pkg::OP_OUT,   8'h00, 1'b0, 1'b0, '0},
      '{tmdu_pkg::OP_LEFT,  8'h00, 1'b0, 1'b0, '0},
      '{tmdu_pkg::OP_OUT,   8'h00, 1'b0, 1'b1, '{8'h01, 1'b1, 1'b0, 1'b0}},
      '{OP_SPARE,           8'h7f, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}},
      '{tmdu_pkg::OP_IN,    8'h00, 1'b0, 1'b0, '0},
      '{tmdu_pkg::OP_TEST,  8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_ops[i])
      send_op(directed_ops[i].code, directed_ops[i].data, directed_ops[i].eof,
              directed_ops[i].typed, directed_ops[i].want);
    drain_results();

    // Random ops, with occasional long walks and a stretch with no idling
    n = 0;
    while (n < RANDOM_ITEMS) begin
      calm = (n >= CALM_FIRST && n < CALM_LAST);
      if ($urandom_range(0, 99) < 3) begin
        burst_len = $urandom_range(10, 80);
        go_right  = ($urandom_range(0, 2) != 0);
        repeat (burst_len) begin
          if ($urandom_range(0, 4) == 0) code = pick_op();
          else if (go_right)
            code = (cell_ptr == LAST_CELL) ? tmdu_pkg::OP_LEFT : tmdu_pkg::OP_RIGHT;
          else code = (cell_ptr == 0) ? tmdu_pkg::OP_RIGHT : tmdu_pkg::OP_LEFT;
          send_random_op(code);
          n++;
        end
      end else begin
        send_random_op(pick_op());
        n++;
      end
      if ($urandom_range(0, 99) == 0) drain_results();
    end
    calm = 1'b0;
    drain_results();

    // Walk back to cell 0 and step off the left end
    fault_side = "left";
    while (cell_ptr != 0) send_random_op(tmdu_pkg::OP_LEFT);
    send_random_op(tmdu_pkg::OP_LEFT);

    // After the fault every op only reports
    for (int c = 0; c < 8; c++) send_op(3'(c), 8'($urandom_range(0, 255)), 1'b0);
    send_op(tmdu_pkg::OP_IN, 8'h5a, 1'b1);
    send_op(tmdu_pkg::OP_OUT, 8'h00, 1'b0);

    op_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("ran %0d ops, %0d results checked, pointer reached cell %0d",
             items_sent, outs_checked, ptr_peak);
    $display("tape fault taken off the %s end, %0d failures", fault_side, fail_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
